// ===== hdl/sahn_pkg.sv =====
package sahn_pkg;

    localparam int MAX_NODES   = 256;
    localparam int NODE_AW     = $clog2(MAX_NODES);
    localparam int NODE_CW     = $clog2(MAX_NODES + 1);
    localparam int MAX_LINKS   = 1024;
    localparam int LINK_AW     = $clog2(MAX_LINKS);
    localparam int LINK_CW     = $clog2(MAX_LINKS + 1);
    localparam int SIG_ENTRIES = 256;
    localparam int SIG_BITS    = $clog2(SIG_ENTRIES);

    // sigmoid argument: Q4.12 rate times Q8.24 excitation
    localparam int X_W = 48;
    localparam logic signed [X_W-1:0] SIG_LIM = X_W'(64'sd8 <<< 36);

    localparam logic [2:0] ACT_CLEAR     = 3'd0;
    localparam logic [2:0] ACT_ADD_NODE  = 3'd1;
    localparam logic [2:0] ACT_ADD_LINK  = 3'd2;
    localparam logic [2:0] ACT_SET_ACT   = 3'd3;
    localparam logic [2:0] ACT_SET_CLAMP = 3'd4;
    localparam logic [2:0] ACT_READ      = 3'd5;
    localparam logic [2:0] ACT_SPREAD    = 3'd6;
    localparam logic [2:0] ACT_UPDATE    = 3'd7;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_IDX = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [2:0] REG_MIN_ACT    = 3'd0;
    localparam logic [2:0] REG_MAX_ACT    = 3'd1;
    localparam logic [2:0] REG_SPREAD     = 3'd2;
    localparam logic [2:0] REG_SELF_GAIN  = 3'd3;
    localparam logic [2:0] REG_MIN_WEIGHT = 3'd4;
    localparam logic [2:0] REG_MAX_WEIGHT = 3'd5;
    localparam logic [2:0] REG_LEARN      = 3'd6;
    localparam logic [2:0] REG_LEAK       = 3'd7;

    typedef struct packed {
        logic [2:0]         action;
        logic [7:0]         node_index;
        logic [7:0]         other_node;
        logic signed [15:0] value;
        logic               clamp_flag;
        logic [7:0]         step_count;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] activity_out;
        logic [1:0]         status;
    } t_out_item;

    typedef logic [15:0] t_sig_tab [SIG_ENTRIES];

    localparam longint unsigned Q30_ONE   = 64'd1 << 30;
    localparam longint unsigned E_INV_Q30 = 64'd395007542;

    // shift-subtract quotient, only used while building the table
    function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
        longint unsigned q, rem;
        q = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // table of sigmoid values at bin centers, unsigned Q0.16, built at elaboration
    function automatic t_sig_tab build_sig();
        t_sig_tab         tab;
        longint unsigned  num, u, e, s, r, term, f, n;
        longint           t, sum;
        int unsigned      k, i;
        for (k = 0; k < SIG_ENTRIES; k++) begin
            num = longint'(2 * k + 1) * (64'd8 << 30);
            t = longint'(num >> SIG_BITS) - (64'sd8 <<< 30);
            u = (t < 0) ? longint'(-t) : longint'(t);
            n = u >> 30;
            f = u & (Q30_ONE - 1);
            term = Q30_ONE;
            sum = longint'(Q30_ONE);
            for (i = 1; i <= 12; i++) begin
                term = udiv64((term * f) >> 30, 64'(i));
                if (i[0]) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            e = longint'(sum);
            while (n > 0) begin
                e = (e * E_INV_Q30) >> 30;
                n = n - 1;
            end
            if (t >= 0) s = udiv64(64'd1 << 60, Q30_ONE + e);
            else s = udiv64(e << 30, Q30_ONE + e);
            r = (s + (64'd1 << 13)) >> 14;
            if (r > 64'd65535) r = 64'd65535;
            tab[k] = r[15:0];
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TAB = build_sig();

endpackage

// ===== hdl/sahn_sigmoid.sv =====
module sahn_sigmoid (
    input  logic                           i_clk,
    input  logic signed [sahn_pkg::X_W-1:0] i_x,
    output logic [15:0]                    o_s
);
    import sahn_pkg::*;

    logic [X_W-1:0]      biased;
    logic [SIG_BITS-1:0] idx;

    assign biased = i_x + SIG_LIM;
    assign idx    = biased[39 -: SIG_BITS];

    always_ff @(posedge i_clk) begin
        if (i_x < -SIG_LIM) begin
            o_s <= SIG_TAB[0];
        end else if (i_x >= SIG_LIM) begin
            o_s <= SIG_TAB[SIG_ENTRIES-1];
        end else begin
            o_s <= SIG_TAB[idx];
        end
    end

endmodule

// ===== hdl/spreading_activation_hebbian_network_top.sv =====
// Spreading-activation network with leaky Hebbian learning. One result item is
// returned per input item. Node activity, clamp flag and excitation live in
// node memories, links in a link memory, each with registered reads, so the
// cost of a command is set by walking those memories one entry at a time: a
// spread seeds excitation node by node, does the two read-modify-writes of
// excitation per link, then updates each node through the sigmoid, once per
// step; a weight update walks the links once. One item is worked at a time; a
// new item is taken while the previous result still waits in the output
// register. No memory needs a clearing pass after reset.
module spreading_activation_hebbian_network_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sahn_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sahn_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import sahn_pkg::*;

    typedef struct packed {
        logic [NODE_AW-1:0] from_node;
        logic [NODE_AW-1:0] to_node;
        logic signed [15:0] weight;
    } t_link;

    typedef enum logic [4:0] {
        S_IDLE, S_READ, S_FIN,
        S_A0, S_A1, S_A2,
        S_L0, S_L1, S_L2, S_L3, S_L4, S_L5, S_L6,
        S_C0, S_C1, S_C2, S_C3, S_C4,
        S_W0, S_W1, S_W2, S_W3, S_W4
    } t_state;

    // configuration
    logic signed [15:0] r_min_act, r_max_act, r_spread, r_self_gain;
    logic signed [15:0] r_min_w, r_max_w, r_learn;
    logic [12:0]        r_leak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_act   <= 16'sd0;
            r_max_act   <= 16'sd4096;
            r_spread    <= 16'sd4096;
            r_self_gain <= 16'sd0;
            r_min_w     <= -16'sd4096;
            r_max_w     <= 16'sd4096;
            r_learn     <= 16'sd410;
            r_leak      <= 13'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MIN_ACT:    r_min_act   <= i_cfg_data;
                REG_MAX_ACT:    r_max_act   <= i_cfg_data;
                REG_SPREAD:     r_spread    <= i_cfg_data;
                REG_SELF_GAIN:  r_self_gain <= i_cfg_data;
                REG_MIN_WEIGHT: r_min_w     <= i_cfg_data;
                REG_MAX_WEIGHT: r_max_w     <= i_cfg_data;
                REG_LEARN:      r_learn     <= i_cfg_data;
                REG_LEAK:       r_leak      <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // memories
    logic signed [15:0] r_act_mem   [MAX_NODES];
    logic               r_clamp_mem [MAX_NODES];
    logic signed [31:0] r_exc_mem   [MAX_NODES];
    t_link              r_link_mem  [MAX_LINKS];

    logic [NODE_AW-1:0] act_raddr, act_waddr, clamp_waddr, exc_raddr, exc_waddr;
    logic [LINK_AW-1:0] link_raddr, link_waddr;
    logic               act_we, clamp_we, exc_we, link_we, clamp_wdata;
    logic signed [15:0] act_wdata, act_q;
    logic               clamp_q;
    logic signed [31:0] exc_wdata, exc_q;
    t_link              link_wdata, link_q;

    always_ff @(posedge i_clk) begin
        if (act_we) r_act_mem[act_waddr] <= act_wdata;
        if (clamp_we) r_clamp_mem[clamp_waddr] <= clamp_wdata;
        act_q   <= r_act_mem[act_raddr];
        clamp_q <= r_clamp_mem[act_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (exc_we) r_exc_mem[exc_waddr] <= exc_wdata;
        exc_q <= r_exc_mem[exc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (link_we) r_link_mem[link_waddr] <= link_wdata;
        link_q <= r_link_mem[link_raddr];
    end

    // control and datapath registers
    t_state              r_state;
    logic [NODE_CW-1:0]  r_nodes;
    logic [LINK_CW-1:0]  r_links;
    logic [LINK_CW-1:0]  r_idx;
    logic [7:0]          r_steps;
    logic [NODE_AW-1:0]  r_from, r_to;
    logic signed [15:0]  r_w, r_act_a;
    logic signed [31:0]  r_prod, r_exc;
    logic signed [X_W-1:0] r_x;
    logic signed [29:0]  r_fw;
    logic signed [33:0]  r_pw;
    logic                r_clamp;
    logic signed [15:0]  r_act_out;
    logic [1:0]          r_status;
    logic                r_out_valid;
    t_out_item           r_out_item;

    logic        in_acc, out_free, node_ok, other_ok, node_full, link_full;
    logic [15:0] sig_s;
    t_state      idle_state;
    logic [1:0]  idle_status;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign node_ok    = NODE_CW'(i_in_item.node_index) < r_nodes;
    assign other_ok   = NODE_CW'(i_in_item.other_node) < r_nodes;
    assign node_full  = r_nodes == NODE_CW'(MAX_NODES);
    assign link_full  = r_links == LINK_CW'(MAX_LINKS);
    assign o_in_stall = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // where an accepted item goes and the status it ends with
    always_comb begin
        idle_state  = S_FIN;
        idle_status = ST_OK;
        case (i_in_item.action)
            ACT_ADD_NODE: begin
                if (node_full) idle_status = ST_FULL;
            end
            ACT_ADD_LINK: begin
                if (!node_ok || !other_ok) idle_status = ST_BAD_IDX;
                else if (link_full) idle_status = ST_FULL;
            end
            ACT_SET_ACT, ACT_SET_CLAMP: begin
                if (!node_ok) idle_status = ST_BAD_IDX;
            end
            ACT_READ: begin
                if (!node_ok) idle_status = ST_BAD_IDX;
                else idle_state = S_READ;
            end
            ACT_SPREAD: begin
                if (i_in_item.step_count != 8'd0) idle_state = S_A0;
            end
            ACT_UPDATE: idle_state = S_W0;
            default: ;
        endcase
    end

    sahn_sigmoid u_sigmoid (
        .i_clk (i_clk),
        .i_x   (r_x),
        .o_s   (sig_s)
    );

    // excitation accumulate with saturation
    logic signed [31:0] exc_base;
    logic signed [32:0] exc_sum;
    logic signed [31:0] exc_sat;
    assign exc_base = (r_state == S_L6) ? exc_q : r_exc;
    assign exc_sum  = 33'(exc_base) + 33'(r_prod);
    always_comb begin
        if (exc_sum > 33'sh0_7FFF_FFFF) exc_sat = 32'sh7FFF_FFFF;
        else if (exc_sum < -33'sh0_8000_0000) exc_sat = 32'sh8000_0000;
        else exc_sat = exc_sum[31:0];
    end

    // new activity: min + round(range * s / 65536)
    logic signed [16:0] act_range;
    logic signed [34:0] pw_round;
    logic signed [19:0] act_sum;
    logic signed [15:0] act_new;
    assign act_range = 17'(r_max_act) - 17'(r_min_act);
    assign pw_round  = 35'(r_pw) + 35'sd32768;
    assign act_sum   = 20'(r_min_act) + 20'($signed(pw_round[34:16]));
    always_comb begin
        if (act_sum > 20'sd32767) act_new = 16'sh7FFF;
        else if (act_sum < -20'sd32768) act_new = 16'sh8000;
        else act_new = act_sum[15:0];
    end

    // weight update: ((1 - leak) * w + learn * a * b) rounded, then clamped
    logic signed [13:0] leak_factor;
    logic signed [48:0] w_sum;
    logic signed [24:0] w_round, w_clamped;
    assign leak_factor = 14'sd4096 - $signed({1'b0, r_leak});
    assign w_sum   = (49'(r_fw) <<< 12) + 49'(r_x) + 49'sd8388608;
    assign w_round = w_sum[48:24];
    always_comb begin
        if (w_round < 25'(r_min_w)) w_clamped = 25'(r_min_w);
        else if (w_round > 25'(r_max_w)) w_clamped = 25'(r_max_w);
        else w_clamped = w_round;
    end

    // memory port control
    always_comb begin
        act_raddr   = r_idx[NODE_AW-1:0];
        exc_raddr   = r_idx[NODE_AW-1:0];
        link_raddr  = r_idx[LINK_AW-1:0];
        act_we      = 1'b0;
        act_waddr   = r_idx[NODE_AW-1:0];
        act_wdata   = act_new;
        clamp_we    = 1'b0;
        clamp_waddr = i_in_item.node_index;
        clamp_wdata = i_in_item.clamp_flag;
        exc_we      = 1'b0;
        exc_waddr   = r_from;
        exc_wdata   = exc_sat;
        link_we     = 1'b0;
        link_waddr  = r_idx[LINK_AW-1:0];
        link_wdata  = '{from_node: r_from, to_node: r_to, weight: w_clamped[15:0]};
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_item.action)
                        ACT_ADD_NODE: begin
                            if (!node_full) begin
                                act_we      = 1'b1;
                                act_waddr   = r_nodes[NODE_AW-1:0];
                                act_wdata   = i_in_item.value;
                                clamp_we    = 1'b1;
                                clamp_waddr = r_nodes[NODE_AW-1:0];
                            end
                        end
                        ACT_ADD_LINK: begin
                            if (node_ok && other_ok && !link_full) begin
                                link_we    = 1'b1;
                                link_waddr = r_links[LINK_AW-1:0];
                                link_wdata = '{from_node: i_in_item.node_index,
                                               to_node:   i_in_item.other_node,
                                               weight:    i_in_item.value};
                            end
                        end
                        ACT_SET_ACT: begin
                            act_we    = node_ok;
                            act_waddr = i_in_item.node_index;
                            act_wdata = i_in_item.value;
                        end
                        ACT_SET_CLAMP: clamp_we = node_ok;
                        ACT_READ:      act_raddr = i_in_item.node_index;
                        default: ;
                    endcase
                end
            end
            S_A2: begin
                exc_we    = 1'b1;
                exc_waddr = r_idx[NODE_AW-1:0];
                exc_wdata = r_prod;
            end
            S_L1, S_W1: act_raddr = link_q.from_node;
            S_L2: begin
                act_raddr = r_to;
                exc_raddr = r_from;
            end
            S_L4: exc_we = 1'b1;
            S_L5: exc_raddr = r_to;
            S_L6: begin
                exc_we    = 1'b1;
                exc_waddr = r_to;
            end
            S_C4: act_we = !r_clamp;
            S_W2: act_raddr = r_to;
            S_W4: link_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nodes     <= '0;
            r_links     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_FIN) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_act_out <= '0;
                        r_status  <= idle_status;
                        r_idx     <= '0;
                        r_steps   <= i_in_item.step_count;
                        r_state   <= idle_state;
                        case (i_in_item.action)
                            ACT_CLEAR: begin
                                r_nodes <= '0;
                                r_links <= '0;
                            end
                            ACT_ADD_NODE: begin
                                if (!node_full) r_nodes <= r_nodes + 1'b1;
                            end
                            ACT_ADD_LINK: begin
                                if (node_ok && other_ok && !link_full) r_links <= r_links + 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: begin
                    r_act_out <= act_q;
                    r_state   <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_item  <= '{activity_out: r_act_out, status: r_status};
                        r_state     <= S_IDLE;
                    end
                end
                // seed excitation with self term
                S_A0: begin
                    if (r_idx >= LINK_CW'(r_nodes)) begin
                        r_idx   <= '0;
                        r_state <= S_L0;
                    end else begin
                        r_state <= S_A1;
                    end
                end
                S_A1: begin
                    r_prod  <= act_q * r_self_gain;
                    r_state <= S_A2;
                end
                S_A2: begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_A0;
                end
                // each link adds to both ends, one read-modify-write at a time
                S_L0: begin
                    if (r_idx >= r_links) begin
                        r_idx   <= '0;
                        r_state <= S_C0;
                    end else begin
                        r_state <= S_L1;
                    end
                end
                S_L1: begin
                    r_from  <= link_q.from_node;
                    r_to    <= link_q.to_node;
                    r_w     <= link_q.weight;
                    r_state <= S_L2;
                end
                S_L2: begin
                    r_act_a <= act_q;
                    r_state <= S_L3;
                end
                S_L3: begin
                    r_prod  <= act_q * r_w;
                    r_exc   <= exc_q;
                    r_state <= S_L4;
                end
                S_L4: r_state <= S_L5;
                S_L5: begin
                    r_prod  <= r_act_a * r_w;
                    r_state <= S_L6;
                end
                S_L6: begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_L0;
                end
                // activity update through the sigmoid
                S_C0: begin
                    if (r_idx >= LINK_CW'(r_nodes)) begin
                        r_idx <= '0;
                        if (r_steps == 8'd1) begin
                            r_state <= S_FIN;
                        end else begin
                            r_steps <= r_steps - 1'b1;
                            r_state <= S_A0;
                        end
                    end else begin
                        r_state <= S_C1;
                    end
                end
                S_C1: begin
                    r_clamp <= clamp_q;
                    r_x     <= r_spread * exc_q;
                    r_state <= S_C2;
                end
                S_C2: r_state <= S_C3;
                S_C3: begin
                    r_pw    <= act_range * $signed({1'b0, sig_s});
                    r_state <= S_C4;
                end
                S_C4: begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_C0;
                end
                // hebbian weight update
                S_W0: begin
                    if (r_idx >= r_links) r_state <= S_FIN;
                    else r_state <= S_W1;
                end
                S_W1: begin
                    r_from  <= link_q.from_node;
                    r_to    <= link_q.to_node;
                    r_w     <= link_q.weight;
                    r_state <= S_W2;
                end
                S_W2: begin
                    r_prod  <= r_learn * act_q;
                    r_state <= S_W3;
                end
                S_W3: begin
                    r_x     <= r_prod * act_q;
                    r_fw    <= leak_factor * r_w;
                    r_state <= S_W4;
                end
                S_W4: begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_W0;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== dv/tb_spreading_activation_hebbian_network_top.sv =====
`timescale 1ns / 100ps

module tb_spreading_activation_hebbian_network_top;
    import sahn_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;
    logic      i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    spreading_activation_hebbian_network_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // network shadow
    longint          sig_lut [SIG_ENTRIES];
    shortint         act_mem [MAX_NODES];
    bit              clamp_mem [MAX_NODES];
    int              exc_mem [MAX_NODES];
    int              link_a [MAX_LINKS];
    int              link_b [MAX_LINKS];
    shortint         link_w [MAX_LINKS];
    int              node_cnt;
    int              link_cnt;
    longint          r_min_act, r_max_act, r_rate, r_self, r_min_w, r_max_w, r_learn, r_leak;

    t_out_item       pending_results[$];
    int              send_idle_pct;
    int              recv_stall_pct;
    int              n_items;
    int              n_checked;
    int              n_errors;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("timeout at %0t", $time);
        $display("tb_spreading_activation_hebbian_network_top: done, errors");
        $finish;
    end

    // sigmoid at bin centers, unsigned Q0.16
    function automatic void fill_sigmoid();
        longint unsigned half_steps, mag, whole, frac, term, ex, quot, rnd;
        longint          centre, acc;
        for (int k = 0; k < SIG_ENTRIES; k++) begin
            half_steps = longint'(2 * k + 1) * (64'd8 << 30);
            centre = longint'(half_steps / SIG_ENTRIES) - (64'sd8 <<< 30);
            mag = (centre < 0) ? -centre : centre;
            whole = mag >> 30;
            frac = mag & ((64'd1 << 30) - 1);
            term = 64'd1 << 30;
            acc = 64'sd1 <<< 30;
            for (int j = 1; j <= 12; j++) begin
                term = ((term * frac) >> 30) / j;
                if (j % 2 == 1) acc = acc - longint'(term);
                else acc = acc + longint'(term);
            end
            ex = acc;
            for (longint unsigned m = 0; m < whole; m++) ex = (ex * 64'd395007542) >> 30;
            if (centre >= 0) quot = (64'd1 << 60) / ((64'd1 << 30) + ex);
            else quot = (ex << 30) / ((64'd1 << 30) + ex);
            rnd = (quot + (64'd1 << 13)) >> 14;
            if (rnd > 65535) rnd = 65535;
            sig_lut[k] = rnd;
        end
    endfunction

    function automatic int clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic shortint clip16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return shortint'(v);
    endfunction

    function automatic void spread_step();
        longint x, lim, s, part;
        longint unsigned bin;
        int a, b;
        lim = 64'sd8 <<< 36;
        for (int i = 0; i < node_cnt; i++) exc_mem[i] = clip32(longint'(act_mem[i]) * r_self);
        for (int i = 0; i < link_cnt; i++) begin
            a = link_a[i];
            b = link_b[i];
            exc_mem[a] = clip32(longint'(exc_mem[a]) + longint'(act_mem[b]) * link_w[i]);
            exc_mem[b] = clip32(longint'(exc_mem[b]) + longint'(act_mem[a]) * link_w[i]);
        end
        for (int i = 0; i < node_cnt; i++) begin
            if (!clamp_mem[i]) begin
                x = r_rate * exc_mem[i];
                if (x < -lim) s = sig_lut[0];
                else if (x >= lim) s = sig_lut[SIG_ENTRIES-1];
                else begin
                    bin = longint'(x + lim) >> 32;
                    if (bin >= SIG_ENTRIES) bin = SIG_ENTRIES - 1;
                    s = sig_lut[bin];
                end
                part = ((r_max_act - r_min_act) * s + 32768) >>> 16;
                act_mem[i] = clip16(r_min_act + part);
            end
        end
    endfunction

    function automatic void hebbian_update();
        longint sum, w;
        for (int i = 0; i < link_cnt; i++) begin
            sum = (4096 - r_leak) * link_w[i] * 4096
                + r_learn * act_mem[link_a[i]] * act_mem[link_b[i]];
            w = (sum + (64'sd1 <<< 23)) >>> 24;
            if (w < r_min_w) w = r_min_w;
            else if (w > r_max_w) w = r_max_w;
            link_w[i] = shortint'(w);
        end
    endfunction

    function automatic t_out_item network_apply(t_in_item it);
        t_out_item res;
        bit        idx_ok;
        res = '0;
        res.status = ST_OK;
        idx_ok = it.node_index < node_cnt;
        case (it.action)
            ACT_CLEAR: begin
                node_cnt = 0;
                link_cnt = 0;
            end
            ACT_ADD_NODE: begin
                if (node_cnt >= MAX_NODES) res.status = ST_FULL;
                else begin
                    act_mem[node_cnt] = it.value;
                    clamp_mem[node_cnt] = it.clamp_flag;
                    node_cnt++;
                end
            end
            ACT_ADD_LINK: begin
                if (!idx_ok || it.other_node >= node_cnt) res.status = ST_BAD_IDX;
                else if (link_cnt >= MAX_LINKS) res.status = ST_FULL;
                else begin
                    link_a[link_cnt] = it.node_index;
                    link_b[link_cnt] = it.other_node;
                    link_w[link_cnt] = it.value;
                    link_cnt++;
                end
            end
            ACT_SET_ACT: begin
                if (!idx_ok) res.status = ST_BAD_IDX;
                else act_mem[it.node_index] = it.value;
            end
            ACT_SET_CLAMP: begin
                if (!idx_ok) res.status = ST_BAD_IDX;
                else clamp_mem[it.node_index] = it.clamp_flag;
            end
            ACT_READ: begin
                if (!idx_ok) res.status = ST_BAD_IDX;
                else res.activity_out = act_mem[it.node_index];
            end
            ACT_SPREAD: begin
                for (int s = 0; s < it.step_count; s++) spread_step();
            end
            default: hebbian_update();
        endcase
        return res;
    endfunction

    // receiver stall
    always @(negedge i_clk) begin
        i_out_stall = (recv_stall_pct > 0) && ($urandom_range(1, 100) <= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result act=%0d status=%0d", $time,
                         o_out_item.activity_out, o_out_item.status);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_out_item.activity_out !== want.activity_out) begin
                    $display("%0t: activity_out expected %0d actual %0d", $time,
                             want.activity_out, o_out_item.activity_out);
                    n_errors++;
                end
                if (o_out_item.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, o_out_item.status);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_item(input t_in_item it);
        @(negedge i_clk);
        while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item = it;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(network_apply(it));
        n_items++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_MIN_ACT:    r_min_act = $signed(data);
            REG_MAX_ACT:    r_max_act = $signed(data);
            REG_SPREAD:     r_rate = $signed(data);
            REG_SELF_GAIN:  r_self = $signed(data);
            REG_MIN_WEIGHT: r_min_w = $signed(data);
            REG_MAX_WEIGHT: r_max_w = $signed(data);
            REG_LEARN:      r_learn = $signed(data);
            default:        r_leak = data[12:0];
        endcase
    endtask

    task automatic cfg_all(input logic [15:0] mn, mx, rate, selfg, mnw, mxw, lrn, lk);
        cfg_write(REG_MIN_ACT, mn);
        cfg_write(REG_MAX_ACT, mx);
        cfg_write(REG_SPREAD, rate);
        cfg_write(REG_SELF_GAIN, selfg);
        cfg_write(REG_MIN_WEIGHT, mnw);
        cfg_write(REG_MAX_WEIGHT, mxw);
        cfg_write(REG_LEARN, lrn);
        cfg_write(REG_LEAK, lk);
    endtask

    // builds a command item from its fields
    function automatic t_in_item make_cmd(logic [2:0] act, logic [7:0] ni, logic [7:0] no,
                                          logic [15:0] val, logic clamp, logic [7:0] steps);
        t_in_item it;
        it.action = act;
        it.node_index = ni;
        it.other_node = no;
        it.value = val;
        it.clamp_flag = clamp;
        it.step_count = steps;
        return it;
    endfunction

    task automatic cmd(logic [2:0] act, logic [7:0] ni = '0, logic [7:0] no = '0,
                       logic [15:0] val = '0, logic clamp = 1'b0, logic [7:0] steps = '0);
        send_item(make_cmd(act, ni, no, val, clamp, steps));
    endtask

    task automatic test_directed_basics();
        cmd(ACT_READ, 0);
        cmd(ACT_ADD_NODE, 0, 0, 16'sh7fff, 1'b0);
        cmd(ACT_ADD_NODE, 0, 0, 16'sh8000, 1'b1);
        cmd(ACT_ADD_NODE, 0, 0, 16'd0, 1'b0);
        cmd(ACT_ADD_LINK, 0, 1, 16'sh7fff);
        cmd(ACT_ADD_LINK, 1, 2, 16'sh8000);
        cmd(ACT_ADD_LINK, 2, 5, 16'd100);
        cmd(ACT_ADD_LINK, 255, 0, 16'd100);
        cmd(ACT_ADD_LINK, 0, 0, 16'd2048);
        cmd(ACT_SET_ACT, 2, 0, 16'd4096);
        cmd(ACT_SET_ACT, 7, 0, 16'd4096);
        cmd(ACT_SET_CLAMP, 0, 0, 0, 1'b1);
        cmd(ACT_SET_CLAMP, 200, 0, 0, 1'b1);
        cmd(ACT_SPREAD, 0, 0, 0, 0, 8'd0);
        cmd(ACT_READ, 2);
        cmd(ACT_SPREAD, 0, 0, 0, 0, 8'd1);
        cmd(ACT_READ, 1);
        cmd(ACT_UPDATE);
        cmd(ACT_SET_CLAMP, 0, 0, 0, 1'b0);
        cmd(ACT_SPREAD, 0, 0, 0, 0, 8'd255);
        cmd(ACT_READ, 0);
        cmd(ACT_READ, 2);
        cmd(ACT_CLEAR);
        cmd(ACT_READ, 0);
        drain();
    endtask

    // small net with a clamped node, spread and learn, then read back
    task automatic exercise_small_net();
        cmd(ACT_CLEAR);
        for (int i = 0; i < 4; i++) cmd(ACT_ADD_NODE, 0, 0, 16'($urandom), i == 3);
        cmd(ACT_ADD_LINK, 0, 1, 16'($urandom));
        cmd(ACT_ADD_LINK, 1, 2, 16'($urandom));
        cmd(ACT_ADD_LINK, 3, 0, 16'($urandom));
        cmd(ACT_UPDATE);
        cmd(ACT_SPREAD, 0, 0, 0, 0, 8'd2);
        cmd(ACT_UPDATE);
        for (int i = 0; i < 4; i++) cmd(ACT_READ, 8'(i));
        drain();
    endtask

    task automatic test_register_extremes();
        cfg_all(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
                16'sh7fff, 16'd8191);
        exercise_small_net();
        // crossed weight limits, negative gains, leak of exactly one
        cfg_all(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh1000, 16'shf000,
                16'sh8000, 16'd4096);
        exercise_small_net();
        cfg_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hffff);
        exercise_small_net();
    endtask

    task automatic run_random(input int count);
        t_in_item it;
        int       r;
        for (int n = 0; n < count; n++) begin
            it = make_cmd(3'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                          1'($urandom), 8'($urandom));
            r = $urandom_range(0, 99);
            if (r < 3) it.action = ACT_CLEAR;
            else if (r < 18 || node_cnt < 2) begin
                it.action = (node_cnt < 10) ? ACT_ADD_NODE : ACT_SET_ACT;
                it.node_index = 8'($urandom_range(0, node_cnt));
            end else if (r < 33 && link_cnt < 14) begin
                it.action = ACT_ADD_LINK;
                if ($urandom_range(0, 9) != 0) begin
                    it.node_index = 8'($urandom_range(0, node_cnt - 1));
                    it.other_node = 8'($urandom_range(0, node_cnt - 1));
                end
            end else if (r < 45) begin
                it.action = ACT_SET_ACT;
                it.node_index = 8'($urandom_range(0, node_cnt));
            end else if (r < 53) begin
                it.action = ACT_SET_CLAMP;
                it.node_index = 8'($urandom_range(0, node_cnt));
            end else if (r < 68) begin
                it.action = ACT_READ;
                if ($urandom_range(0, 9) != 0)
                    it.node_index = 8'($urandom_range(0, node_cnt - 1));
            end else if (r < 85) begin
                it.action = ACT_SPREAD;
                if ($urandom_range(0, 19) != 0) it.step_count = 8'($urandom_range(0, 4));
            end else it.action = ACT_UPDATE;
            send_item(it);
        end
        drain();
    endtask

    task automatic test_random_phases();
        int idle_send [4] = '{0, 51, 0, 34};
        int idle_recv [4] = '{0, 0, 51, 34};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_send[p];
            recv_stall_pct = idle_recv[p];
            if (p == 0) cfg_all(16'd0, 16'd4096, 16'd4096, 16'd0, -16'sd4096, 16'd4096,
                                16'd410, 16'd0);
            else cfg_all(16'($urandom_range(0, 4096) - 2048), 16'($urandom_range(2048, 32767)),
                         16'($urandom), 16'($urandom), 16'($urandom_range(0, 8192) - 8192),
                         16'($urandom_range(0, 8192)), 16'($urandom),
                         16'($urandom_range(0, 8191)));
            run_random(18);
        end
    endtask

    initial begin
        fill_sigmoid();
        node_cnt = 0;
        link_cnt = 0;
        r_min_act = 0; r_max_act = 4096; r_rate = 4096; r_self = 0;
        r_min_w = -4096; r_max_w = 4096; r_learn = 410; r_leak = 0;
        n_items = 0; n_checked = 0; n_errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_basics();
        test_register_extremes();
        test_random_phases();

        repeat (20) @(posedge i_clk);
        $display("covered %0d commands, %0d results compared, %0d mismatches",
                 n_items, n_checked, n_errors);
        $display("directed cases, register extremes, four idle/stall phases");
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("tb_spreading_activation_hebbian_network_top: done, clean");
        end else begin
            $display("tb_spreading_activation_hebbian_network_top: done, errors");
        end
        $finish;
    end

endmodule
